/* rtl/tsdk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsdk_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int CORDIC_DEPTH  = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

    localparam int CW = 29;
    localparam int ZW = 20;

    localparam logic [ZW-1:0] HALF_PI_Q16  = ZW'(102944);
    localparam logic [15:0]   INV_GAIN_Q16 = 16'd39797;

    localparam logic [ZW-1:0] ATAN_Q16 [TAB_LEN] = '{
        20'd51472, 20'd30385, 20'd16055, 20'd8150, 20'd4091, 20'd2047, 20'd1024, 20'd512,
        20'd256,   20'd128,   20'd64,    20'd32,   20'd16,   20'd8,    20'd4,    20'd2,
        20'd1,     20'd0,     20'd0,     20'd0,    20'd0,    20'd0,    20'd0,    20'd0
    };

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_LIMIT = 4'd3;

    localparam logic [15:0] WHEELBASE_RST   = 16'd14614;
    localparam logic [15:0] STEER_GAIN_RST  = 16'd4096;
    localparam logic [11:0] DRIVE_GAIN_RST  = 12'd728;
    localparam logic [14:0] STEER_LIMIT_RST = 15'd11878;

    typedef struct packed {
        logic signed [15:0] forward_speed;
        logic signed [15:0] yaw_rate;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] wheel_angle;
        logic        [15:0] drive_command;
        logic               drive_saturated;
    } res_t;

    typedef struct packed {
        logic               zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

endpackage

`default_nettype wire

/* rtl/tsdk_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsdk_cordic (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             in_valid,
    input  wire tsdk_pkg::cordic_t in_vec,
    output logic                  out_valid,
    output tsdk_pkg::cordic_t     out_vec
);

    localparam int D  = tsdk_pkg::CORDIC_DEPTH;
    localparam int CW = tsdk_pkg::CW;
    localparam int ZW = tsdk_pkg::ZW;

    logic [D:0]        valid_reg;
    tsdk_pkg::cordic_t stage_reg [D+1];
    tsdk_pkg::cordic_t pre_next;

    // quarter-turn pre-rotation into the right half plane
    always_comb
    begin
        pre_next      = in_vec;
        pre_next.zero = (in_vec.x == '0) && (in_vec.y == '0);
        pre_next.z    = '0;
        if (in_vec.x[CW-1])
        begin
            if (!in_vec.y[CW-1])
            begin
                pre_next.x = in_vec.y;
                pre_next.y = -in_vec.x;
                pre_next.z = tsdk_pkg::HALF_PI_Q16;
            end
            else
            begin
                pre_next.x = -in_vec.y;
                pre_next.y = in_vec.x;
                pre_next.z = -tsdk_pkg::HALF_PI_Q16;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= pre_next;
        end
    end

    for (genvar k = 0; k < D; k++)
    begin : g_stage
        tsdk_pkg::cordic_t rot_next;

        always_comb
        begin
            rot_next = stage_reg[k];
            if (!stage_reg[k].y[CW-1])
            begin
                rot_next.x = stage_reg[k].x + (stage_reg[k].y >>> k);
                rot_next.y = stage_reg[k].y - (stage_reg[k].x >>> k);
                rot_next.z = stage_reg[k].z + tsdk_pkg::ATAN_Q16[k];
            end
            else
            begin
                rot_next.x = stage_reg[k].x - (stage_reg[k].y >>> k);
                rot_next.y = stage_reg[k].y + (stage_reg[k].x >>> k);
                rot_next.z = stage_reg[k].z - tsdk_pkg::ATAN_Q16[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[k+1] <= rot_next;
            end
        end
    end

    assign out_valid = valid_reg[D];
    assign out_vec   = stage_reg[D];

`ifndef NO_ASSERTIONS
    a_pre_right_half: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> !stage_reg[0].x[CW-1])
        else $error("pre-rotated x negative");

    a_out_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_vec.x[CW-1])
        else $error("CORDIC magnitude negative");

    a_out_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_vec.z[ZW-1] == out_vec.z[ZW-2]))
        else $error("CORDIC angle out of range");
`endif

endmodule

`default_nettype wire

/* rtl/tricycle_steer_drive_kinematics_unit.sv */
// Tricycle steer/drive inverse kinematics, fully pipelined.
// Command channel (cmd_valid/cmd_ready/cmd_data): forward speed and yaw rate,
// signed Q4.12. Result channel (res_valid/res_ready/res_data): steering angle
// (signed Q3.13, clamped to the steer limit), drive command (0..65535) and a
// flag set when the drive command was clipped.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0
// wheelbase, 1 steer gain, 2 drive gain, 3 steer limit; other indexes are
// ignored. cfg_ready is always high; write only while no command is in flight.
// Pipeline registers in order: input register, wheelbase multiply,
// pre-rotation, 16 CORDIC stages, two gain multiply stages, output register.
// Throughput: one command per cycle while the result is not stalled, set by
// the unrolled CORDIC pipeline.
// Reset clears all valid bits and loads the default register values.
// A stalled result holds the whole pipeline: cmd_ready falls while res_valid
// is high and res_ready low, and nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module tricycle_steer_drive_kinematics_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire tsdk_pkg::cmd_t                   cmd_data,
    output logic                                  res_valid,
    input  wire logic                             res_ready,
    output tsdk_pkg::res_t                        res_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tsdk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [15:0]                      cfg_data
);

    localparam int CW = tsdk_pkg::CW;

    logic        advance;

    logic [15:0] wheelbase_reg;
    logic [15:0] steer_gain_reg;
    logic [11:0] drive_gain_reg;
    logic [14:0] steer_limit_reg;

    logic              s0_valid_reg;
    tsdk_pkg::cmd_t    s0_cmd_reg;

    logic signed [32:0]   yaw_prod;
    logic signed [23:0]   x_scaled;
    tsdk_pkg::cordic_t    s1_next;
    logic                 s1_valid_reg;
    tsdk_pkg::cordic_t    s1_vec_reg;

    logic                 c_valid;
    tsdk_pkg::cordic_t    c_vec;

    logic [CW-2:0]        x_pos;
    logic                 p1_valid_reg;
    logic                 p1_zero_reg;
    logic [43:0]          p1_drive_reg;
    logic signed [36:0]   p1_steer_reg;

    logic [55:0]          drive_prod;
    logic signed [21:0]   steer_shift;
    logic signed [21:0]   steer_lim;
    logic signed [21:0]   steer_clamp;
    logic                 p2_valid_reg;
    logic                 p2_zero_reg;
    logic [19:0]          p2_drive_reg;
    logic signed [15:0]   p2_steer_reg;

    logic                 res_valid_reg;
    tsdk_pkg::res_t       res_next;
    tsdk_pkg::res_t       res_reg;

    assign advance   = !res_valid_reg || res_ready;
    assign cmd_ready = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheelbase_reg   <= tsdk_pkg::WHEELBASE_RST;
            steer_gain_reg  <= tsdk_pkg::STEER_GAIN_RST;
            drive_gain_reg  <= tsdk_pkg::DRIVE_GAIN_RST;
            steer_limit_reg <= tsdk_pkg::STEER_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tsdk_pkg::REG_WHEELBASE:   wheelbase_reg   <= cfg_data;
                tsdk_pkg::REG_STEER_GAIN:  steer_gain_reg  <= cfg_data;
                tsdk_pkg::REG_DRIVE_GAIN:  drive_gain_reg  <= cfg_data[11:0];
                tsdk_pkg::REG_STEER_LIMIT: steer_limit_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // scale yaw rate by wheelbase, widen forward speed
    assign yaw_prod = $signed({1'b0, wheelbase_reg}) * s0_cmd_reg.yaw_rate;
    assign x_scaled = {s0_cmd_reg.forward_speed, 8'h00};

    always_comb
    begin
        s1_next      = '0;
        s1_next.x    = {{(CW-24){x_scaled[23]}}, x_scaled};
        s1_next.y    = {{(CW-27){yaw_prod[32]}}, yaw_prod[32:6]};
    end

    tsdk_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s1_valid_reg),
        .in_vec    (s1_vec_reg),
        .out_valid (c_valid),
        .out_vec   (c_vec)
    );

    assign x_pos = c_vec.x[CW-1] ? '0 : c_vec.x[CW-2:0];

    assign drive_prod  = p1_drive_reg * drive_gain_reg;
    assign steer_shift = p1_steer_reg[36:15];
    assign steer_lim   = $signed({7'b0, steer_limit_reg});

    always_comb
    begin
        priority if (steer_shift > steer_lim)
        begin
            steer_clamp = steer_lim;
        end
        else if (steer_shift < -steer_lim)
        begin
            steer_clamp = -steer_lim;
        end
        else
        begin
            steer_clamp = steer_shift;
        end
    end

    always_comb
    begin
        res_next                 = '0;
        if (!p2_zero_reg)
        begin
            res_next.wheel_angle     = p2_steer_reg;
            res_next.drive_saturated = |p2_drive_reg[19:16];
            res_next.drive_command   = res_next.drive_saturated ? 16'hFFFF
                                                                : p2_drive_reg[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg  <= cmd_valid;
            s1_valid_reg  <= s0_valid_reg;
            p1_valid_reg  <= c_valid;
            p2_valid_reg  <= p1_valid_reg;
            res_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_cmd_reg   <= cmd_data;
            s1_vec_reg   <= s1_next;
            p1_zero_reg  <= c_vec.zero;
            p1_drive_reg <= 44'(x_pos) * 44'(tsdk_pkg::INV_GAIN_Q16);
            p1_steer_reg <= c_vec.z * $signed({1'b0, steer_gain_reg});
            p2_zero_reg  <= p1_zero_reg;
            p2_drive_reg <= drive_prod[55:36];
            p2_steer_reg <= steer_clamp[15:0];
            res_reg      <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef NO_ASSERTIONS
    a_sat_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.drive_saturated |-> res_data.drive_command == 16'hFFFF)
        else $error("saturated drive not at full scale");

    a_stall_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("command taken during result stall");

    a_tail_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance && p2_valid_reg |=> res_valid)
        else $error("result dropped at output stage");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int     ARCTAN_LEN      = 24;
    localparam int     STAGES          = (tsdk_pkg::CORDIC_STAGES < ARCTAN_LEN)
                                         ? tsdk_pkg::CORDIC_STAGES : ARCTAN_LEN;
    localparam longint QUARTER_TURN    = 102944;
    localparam longint MAG_SCALE       = 39797;
    localparam longint DRIVE_MAX       = 65535;
    localparam int     PHASES          = 12;
    localparam int     ITEMS_PER_PHASE = 150;
    localparam int     HOLD_CYCLES     = 80;
    localparam int     SETTLE_CYCLES   = 40;
    localparam int     IDX_W           = tsdk_pkg::CFG_IDX_W;

    localparam logic [IDX_W-1:0] UNUSED_INDEX = 4'd7;

    typedef enum {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [IDX_W-1:0]     index;
        logic [15:0]          value;
        tsdk_pkg::cmd_t       cmd;
        bit                   known;
        tsdk_pkg::res_t       known_res;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cmd_valid;
    logic                 cmd_ready;
    tsdk_pkg::cmd_t       cmd_data;
    logic                 res_valid;
    logic                 res_ready;
    tsdk_pkg::res_t       res_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index;
    logic [15:0]          cfg_data;

    logic                 cmd_known;
    tsdk_pkg::res_t       cmd_known_res;

    longint wheelbase_q14  = 14614;
    longint steer_gain_q12 = 4096;
    longint drive_gain_val = 728;
    longint steer_limit_q13 = 11878;

    longint arctan_q16 [0:ARCTAN_LEN-1] = '{
        51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
        256,   128,   64,    32,   16,   8,    4,    2,
        1,     0,     0,     0,    0,    0,    0,    0
    };

    tsdk_pkg::res_t pending_results[$];
    row_t   directed_rows[$];
    int     mismatches = 0;
    int     sender_idle_pct = 0;
    int     receiver_stall_pct = 0;
    int     hold_requests = 0;

    tricycle_steer_drive_kinematics_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic tsdk_pkg::res_t steer_drive_of(tsdk_pkg::cmd_t c);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        longint steer;
        longint drive;
        int     i;
        tsdk_pkg::res_t r;
        r = '0;
        x = c.forward_speed;
        x = x * 256;
        y = c.yaw_rate;
        y = (wheelbase_q14 * y) >>> 6;
        z = 0;
        if (x == 0 && y == 0)
            return r;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER_TURN;
            end
        end
        for (i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q16[i];
            end
        end
        if (x < 0)
            x = 0;
        drive = (x * MAG_SCALE * drive_gain_val) >>> 36;
        if (drive > DRIVE_MAX)
        begin
            drive = DRIVE_MAX;
            r.drive_saturated = 1'b1;
        end
        r.drive_command = drive[15:0];
        steer = (z * steer_gain_q12) >>> 15;
        if (steer > steer_limit_q13)
            steer = steer_limit_q13;
        if (steer < -steer_limit_q13)
            steer = -steer_limit_q13;
        r.wheel_angle = steer[15:0];
        return r;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endfunction

    always @(posedge clk)
    begin
        tsdk_pkg::res_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tsdk_pkg::REG_WHEELBASE:   wheelbase_q14 = cfg_data;
                    tsdk_pkg::REG_STEER_GAIN:  steer_gain_q12 = cfg_data;
                    tsdk_pkg::REG_DRIVE_GAIN:  drive_gain_val = cfg_data[11:0];
                    tsdk_pkg::REG_STEER_LIMIT: steer_limit_q13 = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (cmd_valid && cmd_ready)
                pending_results.push_back(cmd_known ? cmd_known_res : steer_drive_of(cmd_data));
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                    note_mismatch($sformatf("result transfer with nothing pending: %0d %0d %0d",
                                  res_data.wheel_angle, res_data.drive_command,
                                  res_data.drive_saturated));
                else
                begin
                    want = pending_results.pop_front();
                    if (res_data.wheel_angle !== want.wheel_angle)
                        note_mismatch($sformatf("wheel_angle expected %0d, got %0d",
                                      want.wheel_angle, res_data.wheel_angle));
                    if (res_data.drive_command !== want.drive_command)
                        note_mismatch($sformatf("drive_command expected %0d, got %0d",
                                      want.drive_command, res_data.drive_command));
                    if (res_data.drive_saturated !== want.drive_saturated)
                        note_mismatch($sformatf("drive_saturated expected %0d, got %0d",
                                      want.drive_saturated, res_data.drive_saturated));
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left = 0;
        res_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served < hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_command(tsdk_pkg::cmd_t c, bit known, tsdk_pkg::res_t known_res);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid     <= 1'b1;
        cmd_data      <= c;
        cmd_known     <= known;
        cmd_known_res <= known_res;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    task automatic write_setting(logic [IDX_W-1:0] index, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid and wait for every pending result
    task automatic drain_pipeline();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic void add_row(row_kind_t kind, int a, int b, bit known = 1'b0,
                                    int steer = 0, int drive = 0, bit sat = 1'b0);
        row_t r;
        r.kind                      = kind;
        r.index                     = IDX_W'(a);
        r.value                     = 16'(b);
        r.cmd.forward_speed         = 16'(a);
        r.cmd.yaw_rate              = 16'(b);
        r.known                     = known;
        r.known_res.wheel_angle     = 16'(steer);
        r.known_res.drive_command   = 16'(drive);
        r.known_res.drive_saturated = sat;
        directed_rows.push_back(r);
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endfunction

    function automatic tsdk_pkg::cmd_t random_cmd();
        tsdk_pkg::cmd_t c;
        c.forward_speed = 16'($urandom);
        c.yaw_rate      = 16'($urandom);
        case ($urandom_range(9))
            0, 1:
            begin
                c.forward_speed = 16'(int'($urandom_range(1023)) - 512);
                c.yaw_rate      = 16'(int'($urandom_range(1023)) - 512);
            end
            2: c.forward_speed = pick_extreme();
            3: c.yaw_rate = pick_extreme();
            4: c.forward_speed = '0;
            5: c.yaw_rate = '0;
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] pick_setting();
        case ($urandom_range(4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int          phase;
        int          n;
        logic [15:0] wb_v;
        logic [15:0] sg_v;
        logic [15:0] dg_v;
        logic [15:0] lim_v;

        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd_data      = '0;
        cmd_known     = 1'b0;
        cmd_known_res = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;

        add_row(ROW_CMD, 0, 0, 1'b1, 0, 0, 1'b0);
        add_row(ROW_CMD, 32767, 0);
        add_row(ROW_CMD, -32768, 0);
        add_row(ROW_CMD, 0, 32767);
        add_row(ROW_CMD, 0, -32768);
        add_row(ROW_CMD, 32767, 32767);
        add_row(ROW_CMD, -32768, -32768);
        add_row(ROW_CMD, -32768, 32767);
        add_row(ROW_CMD, 32767, -32768);
        add_row(ROW_CMD, 1, 0);
        add_row(ROW_CMD, -1, 0);
        add_row(ROW_CMD, 0, 1);
        add_row(ROW_CMD, 0, -1);
        add_row(ROW_CMD, -1, -1);
        add_row(ROW_CFG, tsdk_pkg::REG_WHEELBASE, 'hFFFF);
        add_row(ROW_CFG, tsdk_pkg::REG_STEER_GAIN, 0);
        add_row(ROW_CFG, tsdk_pkg::REG_DRIVE_GAIN, 'hFFFF);
        add_row(ROW_CFG, tsdk_pkg::REG_STEER_LIMIT, 'hFFFF);
        add_row(ROW_CMD, 32767, 32767, 1'b1, 0, 65535, 1'b1);
        add_row(ROW_CMD, -32768, -32768, 1'b1, 0, 65535, 1'b1);
        add_row(ROW_CFG, tsdk_pkg::REG_STEER_GAIN, 'hFFFF);
        add_row(ROW_CMD, -32768, 1);
        add_row(ROW_CMD, -32768, -1);
        add_row(ROW_CMD, 1, -1);
        add_row(ROW_CFG, tsdk_pkg::REG_WHEELBASE, 0);
        add_row(ROW_CMD, 0, 12345, 1'b1, 0, 0, 1'b0);
        add_row(ROW_CMD, 0, -32768, 1'b1, 0, 0, 1'b0);
        add_row(ROW_CFG, tsdk_pkg::REG_DRIVE_GAIN, 0);
        add_row(ROW_CFG, tsdk_pkg::REG_STEER_LIMIT, 0);
        add_row(ROW_CMD, 32767, -32768, 1'b1, 0, 0, 1'b0);
        add_row(ROW_CMD, -32768, 32767, 1'b1, 0, 0, 1'b0);
        add_row(ROW_CFG, UNUSED_INDEX, 'h1234);
        add_row(ROW_CMD, -100, 0, 1'b1, 0, 0, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_pipeline();
                write_setting(directed_rows[i].index, directed_rows[i].value);
            end
            else
                send_command(directed_rows[i].cmd, directed_rows[i].known,
                             directed_rows[i].known_res);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_pipeline();
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 48;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 48;
                end
                default:
                begin
                    sender_idle_pct    = 30;
                    receiver_stall_pct = 30;
                end
            endcase
            case (phase)
                1:
                begin
                    wb_v  = 16'hFFFF;
                    sg_v  = 16'hFFFF;
                    dg_v  = 16'hFFFF;
                    lim_v = 16'hFFFF;
                end
                2:
                begin
                    wb_v  = 16'd0;
                    sg_v  = 16'd0;
                    dg_v  = 16'd4095;
                    lim_v = 16'd25735;
                end
                3:
                begin
                    wb_v  = 16'd14614;
                    sg_v  = 16'd4096;
                    dg_v  = 16'd728;
                    lim_v = 16'd11878;
                end
                default:
                begin
                    wb_v  = pick_setting();
                    sg_v  = pick_setting();
                    dg_v  = pick_setting();
                    lim_v = pick_setting();
                end
            endcase
            write_setting(tsdk_pkg::REG_WHEELBASE, wb_v);
            write_setting(tsdk_pkg::REG_STEER_GAIN, sg_v);
            write_setting(tsdk_pkg::REG_DRIVE_GAIN, dg_v);
            write_setting(tsdk_pkg::REG_STEER_LIMIT, lim_v);
            if ($urandom_range(2) == 0)
                write_setting(IDX_W'($urandom_range(2 ** IDX_W - 1,
                              tsdk_pkg::REG_STEER_LIMIT + 1)), 16'($urandom));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // hold the result side off while commands keep coming
                if (phase == 0 && n == 40)
                    hold_requests++;
                if (phase == 5 && n == 75)
                    drain_pipeline();
                send_command(random_cmd(), 1'b0, '0);
            end
        end

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
